// ===== rtl/jfs_pkg.sv =====
// Types and constants shared by the JPEG frame size scanner modules.
package jfs_pkg;

    // Marker byte values
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_RST_LO = 8'hD0;
    localparam logic [7:0] MK_RST_HI = 8'hD7;
    localparam logic [7:0] MK_SOF_LO = 8'hC0;
    localparam logic [7:0] MK_SOF_HI = 8'hCF;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_JPG    = 8'hC8;
    localparam logic [7:0] MK_DAC    = 8'hCC;

    // Index of the last frame header byte that is used (width low byte)
    localparam logic [2:0] FRAME_LAST_IDX = 3'd4;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_SECOND = 4'd1,
        PH_PAIR_A = 4'd2,
        PH_PAIR_B = 4'd3,
        PH_SEEK   = 4'd4,
        PH_LEN_HI = 4'd5,
        PH_LEN_LO = 4'd6,
        PH_FRAME  = 4'd7,
        PH_SKIP   = 4'd8,
        PH_DONE   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NO_START = 3'd1,
        ST_STOP     = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_ENDED    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_result;

endpackage

// ===== rtl/jfs_in_stage.sv =====
// Input register of the scanner: holds one byte transfer until the parser takes it.
module jfs_in_stage
    import jfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output logic       o_in_stall,
    input  logic       i_consume,
    output logic       o_item_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // Stall only while a held byte cannot move on this cycle
    assign o_in_stall = r_valid && !i_consume;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Load payload whenever the register is free
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item.data_byte   <= i_data_byte;
            r_item.end_of_file <= i_end_of_file;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== rtl/jfs_parser.sv =====
// Marker stream parser: one byte per step, emits at most one result per file.
module jfs_parser
    import jfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase      r_phase,     n_phase;
    logic        r_prefix,    n_prefix;
    logic [7:0]  r_marker,    n_marker;
    logic [7:0]  r_len_hi,    n_len_hi;
    logic [15:0] r_skip,      n_skip;
    logic [2:0]  r_frame_idx, n_frame_idx;
    logic [15:0] r_height,    n_height;
    logic [15:0] r_width,     n_width;

    logic        decided;
    t_status     status;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;
    logic [7:0]  b;
    logic        is_sof;

    assign b       = i_item.data_byte;
    assign seg_len = {r_len_hi, b};
    assign skip_dec = r_skip - 16'd1;

    // Frame markers: C0..CF except DHT, JPG and DAC
    always_comb begin
        is_sof = (r_marker inside {[MK_SOF_LO:MK_SOF_HI]}) &&
                 !(r_marker inside {MK_DHT, MK_JPG, MK_DAC});
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_prefix    = r_prefix;
        n_marker    = r_marker;
        n_len_hi    = r_len_hi;
        n_skip      = r_skip;
        n_frame_idx = r_frame_idx;
        n_height    = r_height;
        n_width     = r_width;
        decided     = 1'b0;
        status      = ST_ENDED;
        o_res_valid = 1'b0;

        case (r_phase)
            PH_FIRST: begin
                n_prefix = (b == MK_PREFIX);
                n_phase  = PH_SECOND;
                if (i_item.end_of_file) begin
                    decided = 1'b1;
                    status  = ST_NO_START;
                end
            end
            PH_SECOND: begin
                if (!r_prefix || b != MK_SOI) begin
                    decided = 1'b1;
                    status  = ST_NO_START;
                end else begin
                    n_phase = PH_PAIR_A;
                end
            end
            PH_PAIR_A: begin
                n_prefix = (b == MK_PREFIX);
                n_phase  = PH_PAIR_B;
            end
            PH_SEEK: begin
                if (b == MK_PREFIX) begin
                    n_prefix = 1'b1;
                    n_phase  = PH_PAIR_B;
                end
            end
            PH_PAIR_B: begin
                if (!r_prefix) begin
                    n_phase = PH_SEEK;
                end else begin
                    n_marker = b;
                    if (b == MK_PREFIX) begin
                        // fill byte: stay for the marker byte
                        n_phase = PH_PAIR_B;
                    end else if (b == MK_SOS || b == MK_EOI) begin
                        decided = 1'b1;
                        status  = ST_STOP;
                    end else if (b == MK_SOI || (b inside {[MK_RST_LO:MK_RST_HI]})) begin
                        n_phase = PH_PAIR_A;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (seg_len < 16'd2) begin
                    decided = 1'b1;
                    status  = ST_BAD_LEN;
                end else if (is_sof) begin
                    n_frame_idx = '0;
                    n_phase     = PH_FRAME;
                end else begin
                    n_skip  = seg_len - 16'd2;
                    n_phase = (seg_len == 16'd2) ? PH_PAIR_A : PH_SKIP;
                end
            end
            PH_FRAME: begin
                case (r_frame_idx)
                    3'd1:    n_height = {b, 8'h00};
                    3'd2:    n_height = {r_height[15:8], b};
                    3'd3:    n_width  = {b, 8'h00};
                    3'd4:    n_width  = {r_width[15:8], b};
                    default: ;
                endcase
                if (r_frame_idx >= FRAME_LAST_IDX) begin
                    decided = 1'b1;
                    status  = ST_FOUND;
                end else begin
                    n_frame_idx = r_frame_idx + 3'd1;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_PAIR_A;
                end
            end
            default: ;
        endcase

        o_res.status       = decided ? status : ST_ENDED;
        o_res.image_width  = (decided && status == ST_FOUND) ? n_width  : 16'd0;
        o_res.image_height = (decided && status == ST_FOUND) ? n_height : 16'd0;

        // Give the result, mark done, restart at end of file
        if (r_phase != PH_DONE && (decided || i_item.end_of_file)) begin
            o_res_valid = i_step;
            n_phase     = PH_DONE;
        end
        if (i_item.end_of_file) begin
            n_phase     = PH_FIRST;
            n_prefix    = 1'b0;
            n_marker    = '0;
            n_len_hi    = '0;
            n_skip      = '0;
            n_frame_idx = '0;
            n_height    = '0;
            n_width     = '0;
        end
    end

    // Advance state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_prefix    <= 1'b0;
            r_marker    <= '0;
            r_len_hi    <= '0;
            r_skip      <= '0;
            r_frame_idx <= '0;
            r_height    <= '0;
            r_width     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_prefix    <= n_prefix;
            r_marker    <= n_marker;
            r_len_hi    <= n_len_hi;
            r_skip      <= n_skip;
            r_frame_idx <= n_frame_idx;
            r_height    <= n_height;
            r_width     <= n_width;
        end
    end

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.end_of_file |=> r_phase == PH_FIRST)
        else $error("parser did not restart after end of file");

    a_frame_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME |-> r_frame_idx <= FRAME_LAST_IDX)
        else $error("frame byte index out of range");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> !o_res_valid)
        else $error("second result in one file");

endmodule

// ===== rtl/jfs_out_stage.sv =====
// Output register of the scanner: holds one result until it is taken.
module jfs_out_stage
    import jfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load_en,
    input  logic        i_res_valid,
    input  t_result     i_res,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height
);

    logic    r_valid;
    t_result r_res;

    // Refill valid flag whenever the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load_en) begin
            r_valid <= i_res_valid;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (i_load_en && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_res.status;
    assign o_image_width  = r_res.image_width;
    assign o_image_height = r_res.image_height;

endmodule

// ===== rtl/jpeg_frame_size_scanner.sv =====
// Path: input register, combinational parser, then output register driving o_out_valid.
// Throughput: one byte per cycle, set by the single-step parser between two registers.
// Throughput drops only while a held result is stalled at the output.
// Reset: synchronous active-low i_rst_n empties both registers and restarts the parser.
// At most one result per file; end of file always restarts the scan.
module jpeg_frame_size_scanner
    import jfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height
);

    logic    item_valid;
    t_item   item;
    logic    out_free;
    logic    consume;
    logic    res_valid;
    t_result res;

    // Parser steps when a byte is held and the output slot can take a result
    assign out_free = !o_out_valid || !i_out_stall;
    assign consume  = item_valid && out_free;

    jfs_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_end_of_file(i_end_of_file),
        .o_in_stall   (o_in_stall),
        .i_consume    (consume),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    jfs_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (consume),
        .i_item     (item),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    jfs_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_en     (out_free),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_image_width (o_image_width),
        .o_image_height(o_image_height)
    );

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_ENDED)
        else $error("result status out of range");

    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FOUND |-> o_image_width == 16'd0 &&
                                                o_image_height == 16'd0)
        else $error("nonzero size on a failed scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
                                       $stable(o_image_width) && $stable(o_image_height))
        else $error("stalled result changed");

endmodule
